### rtl/ffa_pkg.sv
// Shared types and codes for the first-fit free-list allocator.
// No dependencies; imported by the controller and the top level.
package ffa_pkg;

  // Request kinds
  typedef enum logic [1:0] {
    KIND_ALLOC = 2'd0,
    KIND_FREE  = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_ALIGN = 3'd1,
    ST_BAD_SIZE  = 3'd2,
    ST_NO_FIT    = 3'd3,
    ST_IGNORED   = 3'd4
  } status_e;

  // Strobes of the record memory port
  typedef struct packed {
    logic we;
    logic re;
  } mem_cmd_t;

endpackage

### rtl/ffa_mem.sv
// Record memory: one write port, one registered read port.
// Entry 0 reads as its reset value until first written. Uses ffa_pkg.
module ffa_mem #(
  parameter int unsigned DEPTH = 8192,
  parameter int unsigned DW    = 33,
  parameter logic [DW-1:0] INIT0 = '0
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ffa_pkg::mem_cmd_t        cmd_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [DW-1:0]            wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [DW-1:0]            rdata_o
);
  import ffa_pkg::*;

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;
  logic          init0_q;
  logic          rd0_q;

  // Write port and registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.we) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (cmd_i.re) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  // Track whether entry 0 still holds its reset value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init0_q <= 1'b1;
      rd0_q   <= 1'b0;
    end else begin
      if (cmd_i.we && waddr_i == '0) begin
        init0_q <= 1'b0;
      end
      if (cmd_i.re) begin
        rd0_q <= init0_q && (raddr_i == '0);
      end
    end
  end

  assign rdata_o = rd0_q ? INIT0 : rdata_q;

endmodule

### rtl/ffa_ctrl.sv
// Request sequencer: list walks, splits, header writes and merges.
// Drives the record memory (ffa_mem) and uses codes from ffa_pkg.
module ffa_ctrl #(
  parameter int unsigned ARENA_BYTES    = 65536,
  parameter int unsigned GRANULE_BYTES  = 8,
  parameter int unsigned HEADER_BYTES   = 16,
  parameter int unsigned MIN_FREE_BYTES = 16,
  localparam int unsigned GRAN_COUNT = ARENA_BYTES / GRANULE_BYTES,
  localparam int unsigned IW  = $clog2(GRAN_COUNT),
  localparam int unsigned GW  = IW + 1,
  localparam int unsigned SW  = $clog2(ARENA_BYTES) + 1,
  localparam int unsigned AW  = (GW > 16) ? GW : 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  logic [1:0]        kind_i,
  input  logic [16:0]       request_size_i,
  input  logic [16:0]       alignment_i,
  input  logic [15:0]       release_offset_i,
  input  logic              release_valid_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output logic [2:0]        res_status_o,
  output logic [15:0]       res_data_o,
  output ffa_pkg::mem_cmd_t mem_cmd_o,
  output logic [IW-1:0]     mem_waddr_o,
  output logic [SW+AW-1:0]  mem_wdata_o,
  output logic [IW-1:0]     mem_raddr_o,
  input  logic [SW+AW-1:0]  mem_rdata_i
);
  import ffa_pkg::*;

  localparam int unsigned NW  = ((SW > 18) ? SW : 18) + 1;
  localparam int unsigned GLG = $clog2(GRANULE_BYTES);
  localparam logic [GW-1:0] NO_LINK = GW'(GRAN_COUNT);

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_ALOOK = 14'b00000000000010,
    S_AEVAL = 14'b00000000000100,
    S_ASPL  = 14'b00000000001000,
    S_ALNK  = 14'b00000000010000,
    S_AHDR  = 14'b00000000100000,
    S_FHDR  = 14'b00000001000000,
    S_FLOOK = 14'b00000010000000,
    S_FSTEP = 14'b00000100000000,
    S_FINS  = 14'b00001000000000,
    S_FLNK  = 14'b00010000000000,
    S_FRMG  = 14'b00100000000000,
    S_FLMG  = 14'b01000000000000,
    S_RESP  = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;
  logic [GW-1:0] head_q, head_d;
  logic [16:0]   size_q, size_d;
  logic [16:0]   align_q, align_d;
  logic [15:0]   hdr_q, hdr_d;
  logic [GW-1:0] curr_q, curr_d;
  logic [GW-1:0] prev_q, prev_d;
  logic [SW-1:0] prev_size_q, prev_size_d;
  logic [GW-1:0] steps_q, steps_d;
  logic [15:0]   pad_q, pad_d;
  logic [NW-1:0] need_q, need_d;
  logic [GW-1:0] nxt_q, nxt_d;
  logic          split_q, split_d;
  logic [GW-1:0] o_q, o_d;
  logic [SW-1:0] o_size_q, o_size_d;
  logic [GW-1:0] o_aux_q, o_aux_d;
  logic [15:0]   orig_q, orig_d;
  logic          right_q, right_d;
  logic [2:0]    status_q, status_d;
  logic [15:0]   data_q, data_d;

  logic [SW-1:0] rd_size;
  logic [AW-1:0] rd_aux;
  logic [GW-1:0] rd_link;
  logic [NW-1:0] addr_n, t_n, need_raw, need_rnd, have_n, rem_n, hdr_n;
  logic [NW-1:0] fhdr_n, forig_n, prev_end;
  logic [16:0]   pad17;
  logic [15:0]   forig;
  logic          align_ok;

  assign rd_size = mem_rdata_i[SW+AW-1:AW];
  assign rd_aux  = mem_rdata_i[AW-1:0];
  assign rd_link = (rd_aux >= AW'(GRAN_COUNT)) ? NO_LINK : GW'(rd_aux);

  // Address arithmetic of the block under the cursor
  always_comb begin
    addr_n   = NW'(curr_q[IW-1:0]) << GLG;
    t_n      = addr_n + NW'(HEADER_BYTES);
    pad17    = (17'(~t_n[16:0]) + 17'd1) & (align_q - 17'd1);
    need_raw = NW'(size_q) + NW'(HEADER_BYTES) + NW'(pad17) + NW'(GRANULE_BYTES - 1);
    need_rnd = (need_raw >> GLG) << GLG;
    have_n   = NW'(rd_size);
    rem_n    = have_n - need_q;
    hdr_n    = addr_n + NW'(pad_q);
    fhdr_n   = NW'(release_offset_i) - NW'(HEADER_BYTES);
    forig    = hdr_q - 16'(rd_aux);
    forig_n  = NW'(forig) + NW'(rd_size);
    prev_end = (NW'(prev_q[IW-1:0]) << GLG) + NW'(prev_size_q);
    align_ok = (alignment_i != '0) && ((alignment_i & (alignment_i - 17'd1)) == '0);
  end

  // Next-state and datapath control
  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    size_d      = size_q;
    align_d     = align_q;
    hdr_d       = hdr_q;
    curr_d      = curr_q;
    prev_d      = prev_q;
    prev_size_d = prev_size_q;
    steps_d     = steps_q;
    pad_d       = pad_q;
    need_d      = need_q;
    nxt_d       = nxt_q;
    split_d     = split_q;
    o_d         = o_q;
    o_size_d    = o_size_q;
    o_aux_d     = o_aux_q;
    orig_d      = orig_q;
    right_d     = right_q;
    status_d    = status_q;
    data_d      = data_q;
    mem_cmd_o   = '0;
    mem_waddr_o = '0;
    mem_wdata_o = '0;
    mem_raddr_o = '0;
    req_ready_o = 1'b0;
    res_valid_o = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          size_d   = request_size_i;
          align_d  = alignment_i;
          hdr_d    = 16'(fhdr_n);
          curr_d   = head_q;
          prev_d   = NO_LINK;
          steps_d  = '0;
          status_d = ST_OK;
          data_d   = '0;
          state_d  = S_RESP;
          case (kind_i)
            KIND_ALLOC: begin
              if (!align_ok) begin
                status_d = ST_BAD_ALIGN;
              end else if (request_size_i == '0) begin
                status_d = ST_BAD_SIZE;
              end else begin
                state_d = S_ALOOK;
              end
            end
            KIND_FREE: begin
              if (!release_valid_i || release_offset_i < 16'(HEADER_BYTES) ||
                  (fhdr_n >> GLG) >= NW'(GRAN_COUNT)) begin
                status_d = ST_IGNORED;
              end else begin
                mem_cmd_o.re = 1'b1;
                mem_raddr_o  = IW'(fhdr_n >> GLG);
                state_d      = S_FHDR;
              end
            end
            KIND_CLEAR: begin
              mem_cmd_o.we = 1'b1;
              mem_waddr_o  = '0;
              mem_wdata_o  = {SW'(ARENA_BYTES), AW'(NO_LINK)};
              head_d       = '0;
            end
            default: ;
          endcase
        end
      end

      // Fetch the next block and size the request against it
      S_ALOOK: begin
        if (curr_q >= NO_LINK || steps_q == NO_LINK) begin
          status_d = ST_NO_FIT;
          state_d  = S_RESP;
        end else begin
          mem_cmd_o.re = 1'b1;
          mem_raddr_o  = curr_q[IW-1:0];
          pad_d        = pad17[15:0];
          need_d       = need_rnd;
          state_d      = S_AEVAL;
        end
      end

      S_AEVAL: begin
        nxt_d = rd_link;
        if (have_n >= need_q) begin
          o_size_d = SW'(rem_n);
          o_d      = GW'((addr_n + need_q) >> GLG);
          split_d  = (rem_n >= NW'(MIN_FREE_BYTES)) &&
                     ((addr_n + need_q) < NW'(ARENA_BYTES));
          if (!((rem_n >= NW'(MIN_FREE_BYTES)) &&
                ((addr_n + need_q) < NW'(ARENA_BYTES)))) begin
            need_d = have_n;
          end
          state_d = S_ASPL;
        end else begin
          prev_d      = curr_q;
          prev_size_d = rd_size;
          curr_d      = rd_link;
          steps_d     = steps_q + 1'b1;
          state_d     = S_ALOOK;
        end
      end

      // Write the split-off remainder
      S_ASPL: begin
        if (split_q) begin
          mem_cmd_o.we = 1'b1;
          mem_waddr_o  = o_q[IW-1:0];
          mem_wdata_o  = {o_size_q, AW'(nxt_q)};
        end
        state_d = S_ALNK;
      end

      // Unlink the allocated block
      S_ALNK: begin
        if (prev_q >= NO_LINK) begin
          head_d = split_q ? o_q : nxt_q;
        end else begin
          mem_cmd_o.we = 1'b1;
          mem_waddr_o  = prev_q[IW-1:0];
          mem_wdata_o  = {prev_size_q, AW'(split_q ? o_q : nxt_q)};
        end
        state_d = S_AHDR;
      end

      // Write the header below the data
      S_AHDR: begin
        if ((hdr_n >> GLG) < NW'(GRAN_COUNT)) begin
          mem_cmd_o.we = 1'b1;
          mem_waddr_o  = IW'(hdr_n >> GLG);
          mem_wdata_o  = {SW'(need_q), AW'(pad_q)};
        end
        data_d  = 16'(hdr_n + NW'(HEADER_BYTES));
        state_d = S_RESP;
      end

      // Check the header of the block to release
      S_FHDR: begin
        if (rd_size == '0 || rd_aux > AW'(hdr_q) || forig[GLG-1:0] != '0 ||
            forig_n > NW'(ARENA_BYTES)) begin
          status_d = ST_IGNORED;
          state_d  = S_RESP;
        end else begin
          orig_d   = forig;
          o_d      = GW'(NW'(forig) >> GLG);
          o_size_d = rd_size;
          state_d  = S_FLOOK;
        end
      end

      // Walk to the insertion point
      S_FLOOK: begin
        if (steps_q != NO_LINK && curr_q < NO_LINK && curr_q < o_q) begin
          mem_cmd_o.re = 1'b1;
          mem_raddr_o  = curr_q[IW-1:0];
          state_d      = S_FSTEP;
        end else if (steps_q != NO_LINK && curr_q == o_q) begin
          status_d = ST_IGNORED;
          state_d  = S_RESP;
        end else begin
          if (steps_q == NO_LINK) begin
            curr_d = NO_LINK;
          end
          state_d = S_FINS;
        end
      end

      S_FSTEP: begin
        prev_d      = curr_q;
        prev_size_d = rd_size;
        curr_d      = rd_link;
        steps_d     = steps_q + 1'b1;
        state_d     = S_FLOOK;
      end

      // Insert the block; fetch the right neighbour if adjacent
      S_FINS: begin
        mem_cmd_o.we = 1'b1;
        mem_waddr_o  = o_q[IW-1:0];
        mem_wdata_o  = {o_size_q, AW'(curr_q)};
        o_aux_d      = curr_q;
        right_d      = (curr_q < NO_LINK) &&
                       ((NW'(orig_q) + NW'(o_size_q)) == (NW'(curr_q[IW-1:0]) << GLG));
        if (right_d) begin
          mem_cmd_o.re = 1'b1;
          mem_raddr_o  = curr_q[IW-1:0];
        end
        state_d = S_FLNK;
      end

      S_FLNK: begin
        if (prev_q >= NO_LINK) begin
          head_d = o_q;
        end else begin
          mem_cmd_o.we = 1'b1;
          mem_waddr_o  = prev_q[IW-1:0];
          mem_wdata_o  = {prev_size_q, AW'(o_q)};
        end
        if (right_q) begin
          o_size_d = o_size_q + rd_size;
          o_aux_d  = rd_link;
        end
        state_d = S_FRMG;
      end

      // Merge with the right neighbour
      S_FRMG: begin
        if (right_q) begin
          mem_cmd_o.we = 1'b1;
          mem_waddr_o  = o_q[IW-1:0];
          mem_wdata_o  = {o_size_q, AW'(o_aux_q)};
        end
        state_d = S_FLMG;
      end

      // Merge with the left neighbour
      S_FLMG: begin
        if (prev_q < NO_LINK && prev_end == NW'(orig_q)) begin
          mem_cmd_o.we = 1'b1;
          mem_waddr_o  = prev_q[IW-1:0];
          mem_wdata_o  = {prev_size_q + o_size_q, AW'(o_aux_q)};
        end
        state_d = S_RESP;
      end

      // Hand the result word to the output register
      S_RESP: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  assign res_status_o = status_q;
  assign res_data_o   = (status_q == ST_OK) ? data_q : '0;

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    size_q      <= size_d;
    align_q     <= align_d;
    hdr_q       <= hdr_d;
    curr_q      <= curr_d;
    prev_q      <= prev_d;
    prev_size_q <= prev_size_d;
    steps_q     <= steps_d;
    pad_q       <= pad_d;
    need_q      <= need_d;
    nxt_q       <= nxt_d;
    split_q     <= split_d;
    o_q         <= o_d;
    o_size_q    <= o_size_d;
    o_aux_q     <= o_aux_d;
    orig_q      <= orig_d;
    right_q     <= right_d;
    status_q    <= status_d;
    data_q      <= data_d;
  end

endmodule

### rtl/first_fit_free_list_allocator.sv
// First-fit free-list allocator top level: record memory, sequencer, output register.
// Depends on ffa_pkg, ffa_mem and ffa_ctrl.
//
// Usage: the input channel (in_valid_i/in_ready_o) takes one request word:
// allocate, free or clear. The output channel (out_valid_o/out_ready_i)
// returns exactly one status/data_offset word per request, in order.
// Free-list state lives in a record memory of one entry per granule,
// read through a registered port; the sequencer does at most one read and
// one write per step. Allocate walks the free list block by block until one
// fits, then writes the split-off remainder, the unlink and the header, or
// reports no fit; free checks the header, walks to the insertion point,
// links the block in and merges it with adjacent neighbours. Rejects, clear
// and unused kinds go straight to the result.
// The list walk through the record memory sets the rate; one request is
// worked on at a time, and the next is taken as soon as the result word
// has moved to the output register, even while that word waits.
// A stalled receiver holds the output register; the sequencer then waits
// with its finished result. Reset empties the output, makes the whole arena
// one free block and needs no clearing pass.
module first_fit_free_list_allocator #(
  parameter int unsigned ARENA_BYTES    = 65536,
  parameter int unsigned GRANULE_BYTES  = 8,
  parameter int unsigned HEADER_BYTES   = 16,
  parameter int unsigned MIN_FREE_BYTES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic [16:0] request_size_i,
  input  logic [16:0] alignment_i,
  input  logic [15:0] release_offset_i,
  input  logic        release_valid_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [15:0] data_offset_o
);
  import ffa_pkg::*;

  localparam int unsigned GRAN_COUNT = ARENA_BYTES / GRANULE_BYTES;
  localparam int unsigned IW = $clog2(GRAN_COUNT);
  localparam int unsigned GW = IW + 1;
  localparam int unsigned SW = $clog2(ARENA_BYTES) + 1;
  localparam int unsigned AW = (GW > 16) ? GW : 16;

  mem_cmd_t          mem_cmd;
  logic [IW-1:0]     mem_waddr, mem_raddr;
  logic [SW+AW-1:0]  mem_wdata, mem_rdata;
  logic              res_valid, res_ready;
  logic [2:0]        res_status;
  logic [15:0]       res_data;
  logic              out_valid_q;
  logic [2:0]        status_q;
  logic [15:0]       data_q;

  ffa_mem #(
    .DEPTH (GRAN_COUNT),
    .DW    (SW + AW),
    .INIT0 ({SW'(ARENA_BYTES), AW'(GRAN_COUNT)})
  ) u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (mem_cmd),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  ffa_ctrl #(
    .ARENA_BYTES    (ARENA_BYTES),
    .GRANULE_BYTES  (GRANULE_BYTES),
    .HEADER_BYTES   (HEADER_BYTES),
    .MIN_FREE_BYTES (MIN_FREE_BYTES)
  ) u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_valid_i      (in_valid_i),
    .req_ready_o      (in_ready_o),
    .kind_i           (kind_i),
    .request_size_i   (request_size_i),
    .alignment_i      (alignment_i),
    .release_offset_i (release_offset_i),
    .release_valid_i  (release_valid_i),
    .res_valid_o      (res_valid),
    .res_ready_i      (res_ready),
    .res_status_o     (res_status),
    .res_data_o       (res_data),
    .mem_cmd_o        (mem_cmd),
    .mem_waddr_o      (mem_waddr),
    .mem_wdata_o      (mem_wdata),
    .mem_raddr_o      (mem_raddr),
    .mem_rdata_i      (mem_rdata)
  );

  // Load the output register when it is empty or being drained
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  // Hold the result word
  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      status_q <= res_status;
      data_q   <= res_data;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign data_offset_o = data_q;

endmodule
